/* hdl/ntcema_pkg.sv */
package ntcema_pkg;

	localparam int CURVE_TABLE_BITS = 8;
	localparam int CHANNELS         = 2;

	localparam int CODE_W     = 15;
	localparam int SHIFT_BITS = CODE_W - CURVE_TABLE_BITS;
	localparam int TABLE_LEN  = (1 << CURVE_TABLE_BITS) + 1;
	localparam int ADDR_W     = CURVE_TABLE_BITS + 1;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int TEMP_W   = 16;
	localparam int CURVE_W  = 20;
	localparam int PROD_W   = CURVE_W + SHIFT_BITS + 2;
	localparam int ALPHA_W  = 9;
	localparam int DIFF_W   = TEMP_W + 1;
	localparam int MUL_W    = ALPHA_W + 1 + DIFF_W;
	localparam int ALPHA_SH = ALPHA_W - 1;

	localparam logic signed [TEMP_W-1:0] CODE_MIN = 16'sd80;
	localparam logic signed [TEMP_W-1:0] CODE_MAX = 16'sd26319;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd6400;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd19200;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd51;
	localparam logic signed [MUL_W-1:0] ALPHA_HALF = MUL_W'(128);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_LOOK_LO = 4'b0010,
		ST_LOOK_HI = 4'b0100,
		ST_FILT    = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic look_lo;
		logic look_hi;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	typedef logic signed [CURVE_W-1:0] curve_tab_t [TABLE_LEN];

	// shift-subtract division, used only while building the curve table
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// floor of n over a positive d
	function automatic longint floor_div_pos(longint n, longint d);
		longint q;
		if (n >= 0)
			q = longint'(udiv64(longint'(n), d));
		else
			q = -longint'(udiv64(longint'(-n + d - 1), d));
		return q;
	endfunction

	// log2 in q16, fraction truncated
	function automatic longint log2_q16(longint unsigned x);
		longint unsigned y;
		longint n;
		longint acc;
		n = 0;
		for (int i = 0; i < 62; i++)
			if ((x >> (i + 1)) != 0)
				n = i + 1;
		if (n <= 30)
			y = x << (30 - n);
		else
			y = x >> (n - 30);
		acc = n * 65536;
		for (int b = 15; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				acc = acc + (64'sd1 << b);
			end
		end
		return acc;
	endfunction

	function automatic longint curve_point(longint c);
		longint num;
		longint den;
		longint l2;
		longint lnq;
		longint d100;
		longint numer;
		longint denom;
		num   = 64'sd4096 * c;
		den   = 64'sd108131100 - num;
		l2    = log2_q16(num) - log2_q16(den);
		lnq   = (l2 * 64'sd2977044472) >>> 32;
		d100  = 64'sd395000 * 64'sd65536 + 64'sd29815 * lnq;
		numer = 64'sd12800 * 64'sd117769250 * 64'sd65536 - 64'sd3496320 * d100;
		denom = 64'sd100 * d100;
		return floor_div_pos(2 * numer + denom, 2 * denom);
	endfunction

	function automatic curve_tab_t build_curve();
		curve_tab_t tab;
		longint c;
		for (int k = 0; k < TABLE_LEN; k++) begin
			c = longint'(k) << SHIFT_BITS;
			if (c < longint'(CODE_MIN))
				c = longint'(CODE_MIN);
			if (c > longint'(CODE_MAX))
				c = longint'(CODE_MAX);
			tab[k] = CURVE_W'(curve_point(c));
		end
		return tab;
	endfunction

	localparam curve_tab_t CURVE = build_curve();

endpackage

/* hdl/ntc_temperature_ema_conditioner_top.sv */
// ntc thermistor conditioner with per-channel exponential smoothing
//
// input stream: s_tdata carries the signed adc code, s_tuser the channel.
// the code is clamped, converted through a beta-curve rom with linear
// interpolation and, if inside -50 .. 150 C, folded into that channel's
// filter. temperatures are signed 1/128 C.
// output stream: one transaction per input, raw and filtered temperature
// in m_tdata, channel, range flag and filter-valid in m_tuser.
// cfg_valid/cfg_data write the filter weight (1/256 units, 51 after reset);
// cfg_ready is always high, write only while the block is idle.
// sequence: after acceptance, lower curve point, upper point with
// interpolation, then filter update into the output register; one item is
// in work at a time, so no new item is taken until the last is committed.
// the output register lets the next item be taken while a result waits.
// if the receiver stalls, the next item stops at the filter step and the
// channel state is not touched until its result can be loaded.
// reset clears the filters and the sample flags and sets the weight to 51.
module ntc_temperature_ema_conditioner_top
	import ntcema_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] adc_code
	input  logic [0:0]  s_tuser,   // [0] channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] raw_temp, [31:16] filtered_temp
	output logic [2:0]  m_tuser,   // [0] out_channel, [1] status, [2] filtered_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	cmd_t               cmd;
	sts_t               sts;
	logic               out_ch, out_st, out_fv;
	logic signed [15:0] out_raw, out_filt;

	assign cfg_ready = 1'b1;

	ntcema_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ntcema_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_channel     (s_tuser[0]),
		.in_code        ($signed(s_tdata)),
		.cfg_we         (cfg_valid),
		.cfg_alpha      (cfg_data),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.out_channel    (out_ch),
		.status         (out_st),
		.raw_temp       (out_raw),
		.filtered_temp  (out_filt),
		.filtered_valid (out_fv)
	);

	assign m_tdata = {out_filt, out_raw};
	assign m_tuser = {out_fv, out_st, out_ch};

	// only one item in work at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// a new result appears only as the controller returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result loaded outside the filter step");

	// an out-of-range result is saturated to a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[15:0] == 16'hE700 || m_tdata[15:0] == 16'h4B00))
		else $error("out-of-range flag without saturated temperature");

	// a channel without a sample reports a zero filter value
	a_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata[31:16] == 16'h0000)
		else $error("filter value present without a sample");

endmodule

/* hdl/ntcema_ctrl.sv */
module ntcema_ctrl
	import ntcema_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_LOOK_LO;
				end
			end
			ST_LOOK_LO: begin
				cmd.look_lo = 1'b1;
				state_d     = ST_LOOK_HI;
			end
			ST_LOOK_HI: begin
				cmd.look_hi = 1'b1;
				state_d     = ST_FILT;
			end
			ST_FILT: begin
				// wait for the output register to have room
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* hdl/ntcema_dpath.sv */
module ntcema_dpath
	import ntcema_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               in_channel,
	input  logic signed [15:0] in_code,
	input  logic               cfg_we,
	input  logic [ALPHA_W-1:0] cfg_alpha,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic               out_channel,
	output logic               status,
	output logic signed [15:0] raw_temp,
	output logic signed [15:0] filtered_temp,
	output logic               filtered_valid
);

	logic                      ch_q;
	logic [CODE_W-1:0]         code_q;
	logic signed [CURVE_W-1:0] elo_q;
	logic signed [TEMP_W-1:0]  t_q;
	logic                      status_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [TEMP_W-1:0]  sm_q [CHANNELS];
	logic                      has_q [CHANNELS];

	logic                      m_tvalid_q;
	logic                      out_ch_q;
	logic                      out_st_q;
	logic signed [TEMP_W-1:0]  out_raw_q;
	logic signed [TEMP_W-1:0]  out_filt_q;
	logic                      out_fv_q;

	logic signed [TEMP_W-1:0]  code_cl;
	logic [ADDR_W-1:0]         rom_addr;
	logic signed [CURVE_W-1:0] rom_data;
	logic signed [PROD_W-1:0]  diff_w, prod_w, tint_w;
	logic signed [SHIFT_BITS:0] frac_s;
	logic signed [TEMP_W-1:0]  t_sat;
	logic                      st_w;

	logic [CH_W-1:0]           ci;
	logic                      ch_ok;
	logic signed [TEMP_W-1:0]  y_w, newy_w, upd_val;
	logic [ALPHA_W-1:0]        a_w;
	logic signed [DIFF_W-1:0]  d_w;
	logic signed [MUL_W-1:0]   mul_w, rnd_w;
	logic                      upd;
	logic                      has_w;

	// input clamp to the usable span
	always_comb begin
		if (in_code < CODE_MIN)
			code_cl = CODE_MIN;
		else if (in_code > CODE_MAX)
			code_cl = CODE_MAX;
		else
			code_cl = in_code;
	end

	// one curve read per cycle: lower point, then upper point
	assign rom_addr = cmd.look_hi ? ADDR_W'(code_q[CODE_W-1:SHIFT_BITS]) + 1'b1
	                              : ADDR_W'(code_q[CODE_W-1:SHIFT_BITS]);
	assign rom_data = CURVE[rom_addr];

	always_comb begin
		frac_s = $signed({1'b0, code_q[SHIFT_BITS-1:0]});
		diff_w = PROD_W'(rom_data) - PROD_W'(elo_q);
		prod_w = diff_w * PROD_W'(frac_s);
		tint_w = PROD_W'(elo_q) + (prod_w >>> SHIFT_BITS);
		st_w   = 1'b0;
		t_sat  = tint_w[TEMP_W-1:0];
		if (tint_w < PROD_W'(TEMP_MIN)) begin
			t_sat = TEMP_MIN;
			st_w  = 1'b1;
		end else if (tint_w > PROD_W'(TEMP_MAX)) begin
			t_sat = TEMP_MAX;
			st_w  = 1'b1;
		end
	end

	// filter: y + round((a * (t - y)) / 256), or t for a channel's first sample
	always_comb begin
		ci      = CH_W'(ch_q);
		ch_ok   = ({31'b0, ch_q} < 32'(CHANNELS));
		y_w     = ch_ok ? sm_q[ci] : '0;
		has_w   = ch_ok ? has_q[ci] : 1'b0;
		a_w     = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		d_w     = DIFF_W'(t_q) - DIFF_W'(y_w);
		mul_w   = MUL_W'($signed({1'b0, a_w})) * MUL_W'(d_w);
		rnd_w   = (mul_w + ALPHA_HALF) >>> ALPHA_SH;
		newy_w  = y_w + rnd_w[TEMP_W-1:0];
		upd     = ch_ok && !status_q;
		upd_val = has_w ? newy_w : t_q;
	end

	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ch_q   <= in_channel;
			code_q <= code_cl[CODE_W-1:0];
		end
		if (cmd.look_lo)
			elo_q <= rom_data;
		if (cmd.look_hi) begin
			t_q      <= t_sat;
			status_q <= st_w;
		end
		if (cmd.commit) begin
			out_ch_q   <= ch_q;
			out_st_q   <= status_q;
			out_raw_q  <= t_q;
			out_filt_q <= upd ? upd_val : y_w;
			out_fv_q   <= has_w || upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			alpha_q    <= ALPHA_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				sm_q[i]  <= '0;
				has_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we)
				alpha_q <= cfg_alpha;
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
				if (upd) begin
					sm_q[ci]  <= upd_val;
					has_q[ci] <= 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign out_channel    = out_ch_q;
	assign status         = out_st_q;
	assign raw_temp       = out_raw_q;
	assign filtered_temp  = out_filt_q;
	assign filtered_valid = out_fv_q;

endmodule
